@@ rtl/core/mfd_pkg.sv @@
`timescale 1ns / 1ps

package mfd_pkg;

  // Default depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // Shortest frame that carries a full feedback record
  localparam logic [3:0] MIN_FRAME_BYTES = 4'd7;

  // Encoder jump beyond which a wrap-around is assumed
  localparam logic signed [16:0] WRAP_POS = 17'sd4096;
  localparam logic signed [16:0] WRAP_NEG = -17'sd4096;

  // Unity filter weight, Q1.16
  localparam logic [16:0] Q16_ONE = 17'h10000;

  localparam logic signed [15:0] TURNS_MAX = 16'sh7fff;
  localparam logic signed [15:0] TURNS_MIN = -16'sh8000;

  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 17;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_ANGLE_SCALE     = 2'd0,
    CFG_SPEED_SMOOTH    = 2'd1,
    CFG_CURRENT_SMOOTH  = 2'd2
  } mfd_cfg_index_t;

  typedef struct packed {
    logic [15:0] angle_scale;
    logic [16:0] speed_weight;
    logic [16:0] current_weight;
  } mfd_cfg_t;

  // One classified frame, as handed from front to back
  typedef struct packed {
    logic [15:0]        encoder;
    logic [31:0]        angle_single;
    logic signed [26:0] speed_sample;   // rpm * 1536, deg/s Q8
    logic signed [15:0] current;
    logic [7:0]         temperature;
  } mfd_item_t;

endpackage

@@ rtl/core/mfd_front.sv @@
`timescale 1ns / 1ps

module mfd_front import mfd_pkg::*; (
  input  logic               in_valid,
  input  logic [3:0]         in_frame_length,
  input  logic [15:0]        in_encoder_count,
  input  logic signed [15:0] in_speed_rpm,
  input  logic signed [15:0] in_current_raw,
  input  logic [7:0]         in_temperature,
  input  logic [15:0]        angle_scale,
  input  logic               q_full,
  output logic               in_stall,
  output logic               push,
  output mfd_item_t          item
);

  logic signed [26:0] rpm_ext;

  assign in_stall = q_full;

  // Short frames are taken and dropped here
  assign push = in_valid && !q_full && (in_frame_length >= MIN_FRAME_BYTES);

  // rpm * 6 * 256 = rpm * (1024 + 512)
  assign rpm_ext = 27'(in_speed_rpm);

  always_comb begin
    item.encoder      = in_encoder_count;
    item.angle_single = 32'(in_encoder_count) * 32'(angle_scale);
    item.speed_sample = (rpm_ext <<< 10) + (rpm_ext <<< 9);
    item.current      = in_current_raw;
    item.temperature  = in_temperature;
  end

endmodule

@@ rtl/core/mfd_queue.sv @@
`timescale 1ns / 1ps

module mfd_queue import mfd_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  mfd_item_t push_item,
  input  logic      pop,
  output logic      full,
  output logic      not_empty,
  output mfd_item_t pop_item
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  mfd_item_t        slot_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;

  assign full      = (count_r == CntW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/core/mfd_back.sv @@
`timescale 1ns / 1ps

module mfd_back import mfd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  mfd_item_t          q_item,
  input  mfd_cfg_t           cfg,
  output logic               pop,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [15:0]        out_encoder_out,
  output logic [31:0]        out_angle_single,
  output logic signed [26:0] out_speed_filtered,
  output logic signed [15:0] out_current_filtered,
  output logic [7:0]         out_temperature_out,
  output logic signed [15:0] out_turn_count,
  output logic signed [47:0] out_angle_total
);

  // State
  logic [15:0]        prev_enc_r;
  logic signed [15:0] turns_r, turns_nxt;
  logic signed [26:0] speed_state_r, speed_nxt;
  logic signed [15:0] current_state_r, current_nxt;

  // Result register
  logic               out_valid_r;
  logic [15:0]        enc_out_r;
  logic [31:0]        single_r;
  logic signed [47:0] total_r, total_nxt;

  logic signed [16:0] enc_diff;
  logic [16:0]        w_speed, w_current;

  logic signed [27:0] spd_delta;
  logic signed [45:0] spd_prod;
  logic signed [46:0] spd_acc, spd_rnd;

  logic signed [16:0] cur_delta;
  logic signed [34:0] cur_prod;
  logic signed [35:0] cur_acc, cur_rnd;

  logic signed [47:0] turns_ext;
  logic [7:0]         temp_r;

  assign pop = q_valid && (!out_valid_r || !out_stall);

  // Turn tracking
  always_comb begin
    enc_diff  = $signed({1'b0, q_item.encoder}) - $signed({1'b0, prev_enc_r});
    turns_nxt = turns_r;
    if (enc_diff > WRAP_POS) begin
      if (turns_r != TURNS_MIN) begin
        turns_nxt = turns_r - 16'sd1;
      end
    end else if (enc_diff < WRAP_NEG) begin
      if (turns_r != TURNS_MAX) begin
        turns_nxt = turns_r + 16'sd1;
      end
    end
  end

  // Weights above unity act as unity
  assign w_speed   = cfg.speed_weight[16]   ? Q16_ONE : cfg.speed_weight;
  assign w_current = cfg.current_weight[16] ? Q16_ONE : cfg.current_weight;

  // old*65536 + w*(sample-old), then divide by 65536 toward zero
  always_comb begin
    spd_delta = $signed({q_item.speed_sample[26], q_item.speed_sample})
              - $signed({speed_state_r[26], speed_state_r});
    spd_prod  = spd_delta * $signed({1'b0, w_speed});
    spd_acc   = $signed({{4{speed_state_r[26]}}, speed_state_r, 16'h0000})
              + $signed({spd_prod[45], spd_prod});
    spd_rnd   = spd_acc + (spd_acc[46] ? 47'sd65535 : 47'sd0);
    speed_nxt = spd_rnd[42:16];

    cur_delta   = $signed({q_item.current[15], q_item.current})
                - $signed({current_state_r[15], current_state_r});
    cur_prod    = cur_delta * $signed({1'b0, w_current});
    cur_acc     = $signed({{4{current_state_r[15]}}, current_state_r, 16'h0000})
                + $signed({cur_prod[34], cur_prod});
    cur_rnd     = cur_acc + (cur_acc[35] ? 36'sd65535 : 36'sd0);
    current_nxt = cur_rnd[31:16];
  end

  // turns * 360 * 65536 as shift-add: 360 = 256 + 64 + 32 + 8
  always_comb begin
    turns_ext = 48'(turns_nxt);
    total_nxt = (turns_ext <<< 24) + (turns_ext <<< 22) + (turns_ext <<< 21)
              + (turns_ext <<< 19) + $signed({16'h0000, q_item.angle_single});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r     <= 1'b0;
      prev_enc_r      <= '0;
      turns_r         <= '0;
      speed_state_r   <= '0;
      current_state_r <= '0;
    end else begin
      if (pop) begin
        out_valid_r     <= 1'b1;
        prev_enc_r      <= q_item.encoder;
        turns_r         <= turns_nxt;
        speed_state_r   <= speed_nxt;
        current_state_r <= current_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      enc_out_r <= q_item.encoder;
      single_r  <= q_item.angle_single;
      temp_r    <= q_item.temperature;
      total_r   <= total_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_encoder_out      = enc_out_r;
  assign out_angle_single     = single_r;
  assign out_speed_filtered   = speed_state_r;
  assign out_current_filtered = current_state_r;
  assign out_temperature_out  = temp_r;
  assign out_turn_count       = turns_r;
  assign out_angle_total      = total_r;

endmodule

@@ rtl/core/motor_feedback_decoder_unit.sv @@
`timescale 1ns / 1ps

// Motor feedback decoder. Takes one decoded feedback frame per transfer and
// returns one result per frame of 7 or more payload bytes; shorter frames are
// taken and dropped without touching any state. Turns are counted from
// encoder wrap-arounds (a jump above +4096 counts down, below -4096 counts up,
// saturating at the 16-bit limits; the first frame is compared against 0).
// Speed (rpm converted to deg/s, Q8) and current are run through first-order
// filters whose new-sample weight is set in Q1.16, truncated toward zero.
// Throughput is one frame per clock unless out_stall holds the output; the
// back end updates turns and both filter states together (speed 28x18, current
// 17x18 multiply-add, each fed back into its state register). Front decode
// feeds the queue, and the back end writes the result register.
// The queue between front and back (QUEUE_DEPTH entries) lets the input keep
// moving while a result waits on out_stall. Configuration registers: index 0
// angle_scale, 1 speed_smoothing, 2 current_smoothing; index 3 is ignored.
// cfg_ready is always high. Write configuration only while no frame is in
// flight.

module motor_feedback_decoder_unit import mfd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [3:0]           in_frame_length,
  input  logic [15:0]          in_encoder_count,
  input  logic signed [15:0]   in_speed_rpm,
  input  logic signed [15:0]   in_current_raw,
  input  logic [7:0]           in_temperature,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          out_encoder_out,
  output logic [31:0]          out_angle_single,
  output logic signed [26:0]   out_speed_filtered,
  output logic signed [15:0]   out_current_filtered,
  output logic [7:0]           out_temperature_out,
  output logic signed [15:0]   out_turn_count,
  output logic signed [47:0]   out_angle_total,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  mfd_cfg_t  cfg_r;
  mfd_item_t front_item, queue_item;
  logic      push, pop, q_full, q_valid;

  // Configuration registers; writes are always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.angle_scale    <= 16'd2880;   // 360/8192 deg per count, Q0.16
      cfg_r.speed_weight   <= Q16_ONE;
      cfg_r.current_weight <= Q16_ONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ANGLE_SCALE:    cfg_r.angle_scale    <= cfg_data[15:0];
        CFG_SPEED_SMOOTH:   cfg_r.speed_weight   <= cfg_data;
        CFG_CURRENT_SMOOTH: cfg_r.current_weight <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: takes frames, drops short ones, precomputes per-frame products
  mfd_front u_front (
    .in_valid         (in_valid),
    .in_frame_length  (in_frame_length),
    .in_encoder_count (in_encoder_count),
    .in_speed_rpm     (in_speed_rpm),
    .in_current_raw   (in_current_raw),
    .in_temperature   (in_temperature),
    .angle_scale      (cfg_r.angle_scale),
    .q_full           (q_full),
    .in_stall         (in_stall),
    .push             (push),
    .item             (front_item)
  );

  // Queue decoupling front from back
  mfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .pop_item  (queue_item)
  );

  // Back: turn counter, filters, total angle, result register
  mfd_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_item               (queue_item),
    .cfg                  (cfg_r),
    .pop                  (pop),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_encoder_out      (out_encoder_out),
    .out_angle_single     (out_angle_single),
    .out_speed_filtered   (out_speed_filtered),
    .out_current_filtered (out_current_filtered),
    .out_temperature_out  (out_temperature_out),
    .out_turn_count       (out_turn_count),
    .out_angle_total      (out_angle_total)
  );

endmodule

@@ tb/sv/motor_feedback_decoder_unit_test.sv @@
`timescale 1ns / 1ps

module motor_feedback_decoder_unit_test;
  import mfd_pkg::*;

  // rpm -> deg/s (x6) in Q8 (x256)
  localparam int RpmToDpsQ8 = 1536;
  localparam longint DegPerTurnQ16 = 64'sd360 * 64'sd65536;
  // index with no register behind it, writes must be dropped
  localparam logic [CfgIndexW-1:0] CfgIndexSpare = 2'd3;

  localparam int QuietLimit    = 5000;  // cycles with no transfer at all
  localparam int HoldCycles    = 300;   // long receiver hold-off
  localparam int ItemsPerPhase = 185;   // full-length frames per random phase
  localparam int NumPhases     = 6;
  localparam int SpinFrames    = 24;    // frames per turn-counter run

  typedef struct packed {
    logic [3:0]         len;
    logic [15:0]        enc;
    logic signed [15:0] rpm;
    logic signed [15:0] cur;
    logic [7:0]         temp;
  } frame_t;

  typedef struct packed {
    logic [15:0]        enc;
    logic [31:0]        single;
    logic signed [26:0] speed;
    logic signed [15:0] current;
    logic [7:0]         temp;
    logic signed [15:0] turns;
    logic signed [47:0] total;
  } feedback_t;

  // Directed row: frame plus, where obvious, the result typed in by hand.
  // Encoder and temperature of a typed result are the frame's own.
  typedef struct packed {
    frame_t             frame;
    logic               typed;
    logic [31:0]        single;
    logic signed [26:0] speed;
    logic signed [15:0] current;
    logic signed [15:0] turns;
    logic signed [47:0] total;
  } stim_row_t;

  // All typed rows run with the reset configuration: angle_scale 2880 and
  // both weights at unity, so the filters pass the sample straight through.
  localparam stim_row_t DirectedRows [17] = '{
    // first frame against encoder 0 after reset
    '{'{4'd8,  16'd0,     16'sd0,     16'sd0,     8'd0},   1'b1,
      32'd0,         27'sd0,         16'sd0,     16'sd0,  48'sd0},
    // short frames with extreme payload: dropped
    '{'{4'd6,  16'hFFFF,  -16'sd1,    -16'sd1,    8'd255}, 1'b0,
      32'd0,         27'sd0,         16'sd0,     16'sd0,  48'sd0},
    '{'{4'd0,  16'h1234,  16'sh8000,  16'sh7FFF,  8'h5A},  1'b0,
      32'd0,         27'sd0,         16'sd0,     16'sd0,  48'sd0},
    // jump of exactly +4096: no wrap; speed/current at max
    '{'{4'd7,  16'd4096,  16'sh7FFF,  16'sh7FFF,  8'd255}, 1'b1,
      32'd11796480,  27'sd50330112,  16'sh7FFF,  16'sd0,  48'sd11796480},
    // +4097: one turn down; speed/current at min
    '{'{4'd8,  16'd8193,  16'sh8000,  16'sh8000,  8'd128}, 1'b1,
      32'd23595840,  -27'sd50331648, 16'sh8000,  -16'sd1, 48'sd2880},
    // -8193 back to zero, length 15 taken as full frame
    '{'{4'd15, 16'd0,     16'sd1,     16'sd1,     8'd1},   1'b1,
      32'd0,         27'sd1536,      16'sd1,     16'sd0,  48'sd0},
    // full-scale encoder
    '{'{4'd9,  16'hFFFF,  -16'sd1,    -16'sd1,    8'd254}, 1'b1,
      32'd188740800, -27'sd1536,     -16'sd1,    -16'sd1, 48'sd165147840},
    // exactly -4096: no wrap
    '{'{4'd12, 16'd61439, 16'sd0,     16'sd0,     8'd7},   1'b1,
      32'd176944320, 27'sd0,         16'sd0,     -16'sd1, 48'sd153351360},
    // -4097, +4097, short frame in between must not disturb the state
    '{'{4'd10, 16'd57342, 16'sh1000,  -16'sd100,  8'd30},  1'b0,
      32'd0,         27'sd0,         16'sd0,     16'sd0,  48'sd0},
    '{'{4'd5,  16'd0,     16'sh7FFF,  16'sh8000,  8'd255}, 1'b0,
      32'd0,         27'sd0,         16'sd0,     16'sd0,  48'sd0},
    '{'{4'd8,  16'd61439, -16'sd2,    16'sd2,     8'd40},  1'b0,
      32'd0,         27'sd0,         16'sd0,     16'sd0,  48'sd0},
    '{'{4'd7,  16'd0,     16'sh2000,  16'sh7000,  8'd41},  1'b0,
      32'd0,         27'sd0,         16'sd0,     16'sd0,  48'sd0},
    // alternating bit patterns
    '{'{4'd14, 16'h5555,  16'sh5555,  16'shAAAA,  8'hAA},  1'b0,
      32'd0,         27'sd0,         16'sd0,     16'sd0,  48'sd0},
    '{'{4'd13, 16'hAAAA,  16'shAAAA,  16'sh5555,  8'h55},  1'b0,
      32'd0,         27'sd0,         16'sd0,     16'sd0,  48'sd0},
    '{'{4'd1,  16'hFFFF,  -16'sd1,    -16'sd1,    8'd255}, 1'b0,
      32'd0,         27'sd0,         16'sd0,     16'sd0,  48'sd0},
    '{'{4'd11, 16'h8000,  16'sh4000,  -16'sd4,    8'd60},  1'b0,
      32'd0,         27'sd0,         16'sd0,     16'sd0,  48'sd0},
    '{'{4'd7,  16'h7FFF,  16'shC000,  16'sd4,     8'd61},  1'b0,
      32'd0,         27'sd0,         16'sd0,     16'sd0,  48'sd0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [3:0]            in_frame_length = '0;
  logic [15:0]           in_encoder_count = '0;
  logic signed [15:0]    in_speed_rpm = '0;
  logic signed [15:0]    in_current_raw = '0;
  logic [7:0]            in_temperature = '0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [15:0]           out_encoder_out;
  logic [31:0]           out_angle_single;
  logic signed [26:0]    out_speed_filtered;
  logic signed [15:0]    out_current_filtered;
  logic [7:0]            out_temperature_out;
  logic signed [15:0]    out_turn_count;
  logic signed [47:0]    out_angle_total;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CfgIndexW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0]   cfg_data = '0;

  // Predictor state, mirrors the block after every accepted frame
  logic [15:0]        last_enc = '0;
  logic signed [15:0] turn_cnt = '0;
  int                 speed_acc = 0;
  int                 current_acc = 0;
  logic [15:0]        scale_reg = 16'd2880;
  logic [16:0]        speed_wt = Q16_ONE;
  logic [16:0]        current_wt = Q16_ONE;

  feedback_t pending_feedback[$];
  int        fault_cnt = 0;
  int        quiet_cycles = 0;
  bit        steady = 1'b0;   // no idling on either side while set
  int        hold_cycles = 0; // receiver hold-off request

  motor_feedback_decoder_unit i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_frame_length      (in_frame_length),
    .in_encoder_count     (in_encoder_count),
    .in_speed_rpm         (in_speed_rpm),
    .in_current_raw       (in_current_raw),
    .in_temperature       (in_temperature),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_encoder_out      (out_encoder_out),
    .out_angle_single     (out_angle_single),
    .out_speed_filtered   (out_speed_filtered),
    .out_current_filtered (out_current_filtered),
    .out_temperature_out  (out_temperature_out),
    .out_turn_count       (out_turn_count),
    .out_angle_total      (out_angle_total),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // First-order low-pass: ((1 - w) * old + w * sample), Q1.16 weight clipped
  // at unity, division truncating toward zero.
  function automatic int filter_step(input int old_v, input int sample,
                                     input logic [16:0] w);
    longint wt;
    longint acc;
    wt = (w > Q16_ONE) ? longint'(Q16_ONE) : longint'(w);
    acc = (longint'(Q16_ONE) - wt) * longint'(old_v) + wt * longint'(sample);
    return int'(acc / longint'(Q16_ONE));
  endfunction

  // Advances the predictor by one frame; returns 1 if the frame yields a result.
  function automatic bit decode_frame(input frame_t f, output feedback_t r);
    int step;
    r = '0;
    if (f.len < MIN_FRAME_BYTES) return 1'b0;
    step = int'(f.enc) - int'(last_enc);
    last_enc = f.enc;
    // forward wrap past the top counts a turn down, backward wrap a turn up
    if (step > int'(WRAP_POS)) begin
      if (turn_cnt != TURNS_MIN) turn_cnt = turn_cnt - 16'sd1;
    end else if (step < int'(WRAP_NEG)) begin
      if (turn_cnt != TURNS_MAX) turn_cnt = turn_cnt + 16'sd1;
    end
    speed_acc = filter_step(speed_acc, int'(f.rpm) * RpmToDpsQ8, speed_wt);
    current_acc = filter_step(current_acc, int'(f.cur), current_wt);
    r.enc = f.enc;
    r.single = 32'(f.enc) * 32'(scale_reg);
    r.speed = 27'(speed_acc);
    r.current = 16'(current_acc);
    r.temp = f.temp;
    r.turns = turn_cnt;
    r.total = 48'(longint'(turn_cnt) * DegPerTurnQ16 + longint'(r.single));
    return 1'b1;
  endfunction

  function automatic logic signed [15:0] pick_s16();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return 16'(int'($urandom_range(0, 100)) - 50);
      default: return 16'($urandom);
    endcase
  endfunction

  // Random frame; encoder mostly moves relative to the last one so that
  // both wrap directions and the threshold edges get hit often.
  function automatic frame_t random_frame();
    frame_t f;
    int d;
    int pos;
    f.len = ($urandom_range(0, 99) < 15) ? 4'($urandom_range(0, 6))
                                         : 4'($urandom_range(7, 15));
    case ($urandom_range(0, 5))
      0: d = int'($urandom_range(0, 65535)) - int'(last_enc);
      1: d = (4095 + int'($urandom_range(0, 2))) * ($urandom_range(0, 1) ? 1 : -1);
      2: d = int'($urandom_range(0, 8192)) - 4096;
      3: d = $urandom_range(0, 1) ? 65535 - int'(last_enc) : -int'(last_enc);
      default: d = int'($urandom_range(0, 600)) - 300;
    endcase
    pos = int'(last_enc) + d;
    if (pos < 0 || pos > 65535) pos = int'(last_enc) - d;
    f.enc = pos[15:0];
    f.rpm = pick_s16();
    f.cur = pick_s16();
    f.temp = 8'($urandom);
    return f;
  endfunction

  // One input transfer. Valid is only lowered for an idle gap, so back-to-back
  // frames keep it high across the accepting edge.
  task automatic send_frame(input frame_t f, input bit typed, input feedback_t given);
    feedback_t r;
    if (!steady) begin
      while ($urandom_range(0, 99) < 35) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_frame_length <= f.len;
    in_encoder_count <= f.enc;
    in_speed_rpm <= f.rpm;
    in_current_raw <= f.cur;
    in_temperature <= f.temp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (decode_frame(f, r)) pending_feedback.push_back(typed ? given : r);
  endtask

  // Sender stops until all results are back, then allows for the pipeline
  // (two stages) so nothing is in flight afterwards.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_feedback.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [CfgIndexW-1:0] idx,
                           input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ANGLE_SCALE:    scale_reg = data[15:0];
      CFG_SPEED_SMOOTH:   speed_wt = data;
      CFG_CURRENT_SMOOTH: current_wt = data;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [CfgDataW-1:0] scale,
                              input logic [CfgDataW-1:0] spd_w,
                              input logic [CfgDataW-1:0] cur_w);
    drain();
    write_reg(CFG_ANGLE_SCALE, scale);
    write_reg(CFG_SPEED_SMOOTH, spd_w);
    write_reg(CFG_CURRENT_SMOOTH, cur_w);
    cfg_valid <= 1'b0;
  endtask

  // Moves the turn counter steadily in one direction: a wrap step
  // (|jump| > 4096) where the encoder has room, else a return step that
  // stays within 4096.
  task automatic spin_turns(input bit downward, input int frames);
    frame_t f;
    int room;
    for (int k = 0; k < frames; k++) begin
      f = random_frame();
      f.len = 4'($urandom_range(7, 15));
      if (downward) begin
        if (last_enc <= 16'd61438) begin
          room = 61438 - int'(last_enc);
          f.enc = 16'(int'(last_enc) + 4097 + int'($urandom_range(0, (room < 200) ? room : 200)));
        end else begin
          f.enc = last_enc - 16'd4096;
        end
      end else begin
        if (last_enc >= 16'd4097) begin
          room = int'(last_enc) - 4097;
          f.enc = 16'(int'(last_enc) - 4097 - int'($urandom_range(0, (room < 200) ? room : 200)));
        end else begin
          f.enc = last_enc + 16'd4096;
        end
      end
      send_frame(f, 1'b0, '0);
    end
  endtask

  function automatic void report_fault(input string what, input feedback_t want,
                                       input feedback_t seen);
    fault_cnt++;
    if (fault_cnt <= 10) begin
      $display("MISMATCH %s at %0t", what, $realtime);
      $display("  exp enc=%h single=%h speed=%0d cur=%0d temp=%0d turns=%0d total=%0d",
               want.enc, want.single, want.speed, want.current, want.temp,
               want.turns, want.total);
      $display("  got enc=%h single=%h speed=%0d cur=%0d temp=%0d turns=%0d total=%0d",
               seen.enc, seen.single, seen.speed, seen.current, seen.temp,
               seen.turns, seen.total);
    end
  endfunction

  // Receiver: random stalls, or a long counted hold-off when requested so the
  // block backs up into its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        out_stall <= !steady && ($urandom_range(0, 99) < 35);
      end
    end
  end

  // Result checker: every result transfer against the oldest expectation
  always @(posedge clk) begin
    feedback_t seen;
    feedback_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen.enc = out_encoder_out;
      seen.single = out_angle_single;
      seen.speed = out_speed_filtered;
      seen.current = out_current_filtered;
      seen.temp = out_temperature_out;
      seen.turns = out_turn_count;
      seen.total = out_angle_total;
      if (pending_feedback.size() == 0) begin
        report_fault("result with nothing pending", '0, seen);
      end else begin
        want = pending_feedback.pop_front();
        if (seen.enc !== want.enc || seen.single !== want.single ||
            seen.speed !== want.speed || seen.current !== want.current ||
            seen.temp !== want.temp || seen.turns !== want.turns ||
            seen.total !== want.total)
          report_fault("result fields", want, seen);
      end
    end
  end

  // Watchdog: any transfer on any channel resets the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    feedback_t given;
    int n;
    frame_t f;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // unused index must not touch any register; reset values stay in force
    write_reg(CfgIndexSpare, '1);
    cfg_valid <= 1'b0;

    for (int i = 0; i < $size(DirectedRows); i++) begin
      given.enc = DirectedRows[i].frame.enc;
      given.single = DirectedRows[i].single;
      given.speed = DirectedRows[i].speed;
      given.current = DirectedRows[i].current;
      given.temp = DirectedRows[i].frame.temp;
      given.turns = DirectedRows[i].turns;
      given.total = DirectedRows[i].total;
      send_frame(DirectedRows[i].frame, DirectedRows[i].typed, given);
    end

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        // bit 16 of the angle write is dropped: scale becomes 0
        0: program_regs(17'h10000, Q16_ONE, Q16_ONE);
        // max scale, filters frozen
        1: program_regs(17'h0FFFF, 17'd0, 17'd0);
        2: program_regs(17'($urandom_range(0, 65535)), 17'd1, 17'h0FFFF);
        // weights above unity act as unity
        3: program_regs(17'($urandom_range(0, 65535)), 17'h1FFFF, 17'h10001);
        4: program_regs(17'($urandom_range(0, 65535)), 17'($urandom_range(0, 65536)),
                        17'($urandom_range(0, 65536)));
        default: program_regs(17'd2880, 17'd32768, 17'd16384);
      endcase
      steady = (phase == 4);
      // receiver holds off while the sender keeps offering frames
      if (phase == 2) hold_cycles = HoldCycles;
      n = 0;
      while (n < ItemsPerPhase) begin
        f = random_frame();
        send_frame(f, 1'b0, '0);
        if (f.len >= MIN_FRAME_BYTES) begin
          n++;
          if (phase == 3 && n == ItemsPerPhase / 2) drain();
        end
      end
    end

    // turn counter run down and up, back-to-back transfers
    program_regs(17'($urandom_range(0, 65535)), 17'($urandom_range(0, 65536)),
                 17'($urandom_range(0, 65536)));
    steady = 1'b1;
    spin_turns(1'b1, SpinFrames);
    spin_turns(1'b0, SpinFrames);
    steady = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    if (fault_cnt == 0 && pending_feedback.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
